/* rtl/core/xrs_pkg.sv */
// Package for the xoroshiro128+ generator: payload structs, internal structs,
// SplitMix64 and xoroshiro constants, and the seed expander state type.
// It has no dependencies.
package xrs_pkg;

  localparam logic [63:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned ROT_A   = 55;
  localparam int unsigned SHIFT_A = 14;
  localparam int unsigned ROT_B   = 36;

  localparam int unsigned FRAC_MSB = 63;
  localparam int unsigned FRAC_LSB = 40;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_SEED = 1'b0;

  typedef struct packed {
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } xrs_req_t;

  typedef struct packed {
    logic        [63:0] raw_value;
    logic        [23:0] unit_fraction;
    logic signed [31:0] scaled_value;
  } xrs_rsp_t;

  typedef struct packed {
    logic               busy;
    logic               load;
    logic        [63:0] word_a;
    logic        [63:0] word_b;
  } xrs_seed_t;

  typedef struct packed {
    logic        [63:0] raw;
    logic signed [31:0] low;
    logic signed [32:0] span;
  } xrs_mid_t;

  typedef enum logic [2:0] {
    EXP_IDLE,
    EXP_START,
    EXP_ADD,
    EXP_MUL,
    EXP_MIX
  } xrs_exp_state_e;

  function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

endpackage

/* rtl/core/xrs_fifo.sv */
// Small first-in first-out queue built from flip-flops with a fill count.
// It has no dependencies.
module xrs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  always_comb begin
    full_o   = (count_q == CntW'(Depth));
    empty_o  = (count_q == '0);
    do_push  = push_i & ~full_o;
    do_pop   = pop_i & ~empty_o;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/xrs_seed_expander.sv */
// Seed register and SplitMix64 sequencer that expands the seed into two state words.
// Each 64-bit product is built from 32x32 partial products on one shared multiplier.
// Depends on xrs_pkg.
module xrs_seed_expander import xrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_data_i,
  output logic [63:0] seed_o,
  output xrs_seed_t   exp_o
);

  xrs_exp_state_e state_q, state_d;
  logic [63:0] seed_q, seed_d;
  logic [63:0] sm_acc_q, sm_acc_d;
  logic [63:0] z_q, z_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] word_a_q, word_a_d;
  logic [1:0]  phase_q, phase_d;
  logic        mul_sel_q, mul_sel_d;
  logic        word_sel_q, word_sel_d;
  logic [63:0] mul_const, sm_next, mix_full, fin;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        load;

  always_comb begin
    mul_const = mul_sel_q ? SM_MUL2 : SM_MUL1;
    unique case (phase_q)
      2'd0: begin
        mul_a = z_q[31:0];
        mul_b = mul_const[31:0];
      end
      2'd1: begin
        mul_a = z_q[63:32];
        mul_b = mul_const[31:0];
      end
      2'd2: begin
        mul_a = z_q[31:0];
        mul_b = mul_const[63:32];
      end
      default: begin
        mul_a = z_q[31:0];
        mul_b = mul_const[31:0];
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_d   = mul_p;
  assign sm_next  = sm_acc_q + SM_GAMMA;
  assign mix_full = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
  assign fin      = acc_q ^ (acc_q >> 31);

  always_comb begin
    state_d    = state_q;
    seed_d     = seed_q;
    sm_acc_d   = sm_acc_q;
    z_d        = z_q;
    acc_d      = acc_q;
    word_a_d   = word_a_q;
    phase_d    = phase_q;
    mul_sel_d  = mul_sel_q;
    word_sel_d = word_sel_q;
    load       = 1'b0;
    unique case (state_q)
      EXP_IDLE: begin
      end
      EXP_START: begin
        sm_acc_d   = (seed_q == '0) ? 64'd1 : seed_q;
        word_sel_d = 1'b0;
        state_d    = EXP_ADD;
      end
      EXP_ADD: begin
        sm_acc_d  = sm_next;
        z_d       = sm_next ^ (sm_next >> 30);
        mul_sel_d = 1'b0;
        phase_d   = 2'd0;
        state_d   = EXP_MUL;
      end
      EXP_MUL: begin
        phase_d = phase_q + 2'd1;
        unique case (phase_q)
          2'd0: begin
          end
          2'd1: begin
            acc_d = prod_q;
          end
          2'd2: begin
            acc_d[63:32] = acc_q[63:32] + prod_q[31:0];
          end
          default: begin
            if (!mul_sel_q) begin
              z_d       = mix_full ^ (mix_full >> 27);
              mul_sel_d = 1'b1;
            end else begin
              acc_d   = mix_full;
              state_d = EXP_MIX;
            end
          end
        endcase
      end
      EXP_MIX: begin
        if (!word_sel_q) begin
          word_a_d   = fin;
          word_sel_d = 1'b1;
          state_d    = EXP_ADD;
        end else begin
          load    = 1'b1;
          state_d = EXP_IDLE;
        end
      end
      default: begin
        state_d = EXP_START;
      end
    endcase
    if (cfg_we_i) begin
      seed_d  = cfg_data_i;
      state_d = EXP_START;
    end
  end

  assign seed_o       = seed_q;
  assign exp_o.busy   = (state_q != EXP_IDLE);
  assign exp_o.load   = load;
  assign exp_o.word_a = word_a_q;
  assign exp_o.word_b = fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= EXP_START;
      seed_q     <= 64'd1;
      phase_q    <= 2'd0;
      mul_sel_q  <= 1'b0;
      word_sel_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      seed_q     <= seed_d;
      phase_q    <= phase_d;
      mul_sel_q  <= mul_sel_d;
      word_sel_q <= word_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sm_acc_q <= sm_acc_d;
    z_q      <= z_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    word_a_q <= word_a_d;
  end

endmodule

/* rtl/core/xrs_front.sv */
// Front end: accepts requests, draws one xoroshiro128+ word per beat and forms the span.
// Holds the two generator state words. Depends on xrs_pkg.
module xrs_front import xrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  xrs_seed_t exp_i,
  input  logic      push_i,
  input  xrs_req_t  req_i,
  output logic      full_o,
  output logic      mid_push_o,
  output xrs_mid_t  mid_data_o,
  input  logic      mid_full_i
);

  logic [63:0] gen_a_q, gen_a_d;
  logic [63:0] gen_b_q, gen_b_d;
  logic [63:0] s1x;
  logic        accept;

  always_comb begin
    full_o  = exp_i.busy | mid_full_i;
    accept  = push_i & ~full_o;
    s1x     = gen_a_q ^ gen_b_q;
    gen_a_d = gen_a_q;
    gen_b_d = gen_b_q;
    if (exp_i.load) begin
      gen_a_d = exp_i.word_a;
      gen_b_d = exp_i.word_b;
    end else if (accept) begin
      gen_a_d = rotl64(gen_a_q, ROT_A) ^ s1x ^ (s1x << SHIFT_A);
      gen_b_d = rotl64(s1x, ROT_B);
    end
    mid_push_o      = accept;
    mid_data_o.raw  = gen_a_q + gen_b_q;
    mid_data_o.low  = req_i.range_low;
    mid_data_o.span = {req_i.range_high[31], req_i.range_high}
                    - {req_i.range_low[31], req_i.range_low};
  end

  logic rst_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_seen_q <= 1'b0;
    end else begin
      rst_seen_q <= rst_seen_q | exp_i.load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exp_i.load || (accept && rst_seen_q)) begin
      gen_a_q <= gen_a_d;
      gen_b_q <= gen_b_d;
    end
  end

endmodule

/* rtl/core/xrs_back.sv */
// Back end: multiplies span by the unit fraction, floors, adds the low end and queues results.
// Depends on xrs_pkg and xrs_fifo.
module xrs_back import xrs_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     mid_empty_i,
  input  xrs_mid_t mid_data_i,
  output logic     mid_pop_o,
  input  logic     out_pop_i,
  output logic     out_empty_o,
  output xrs_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic               s1_valid_q;
  logic        [63:0] raw_q;
  logic signed [31:0] low_q;
  logic signed [57:0] prod_q, prod_d;
  logic        [23:0] frac;
  logic [CntW-1:0]    out_count;
  logic               out_full;
  logic               credit;
  xrs_rsp_t           rsp_d, rsp_q;

  always_comb begin
    credit    = ({1'b0, out_count} + (CntW + 1)'(s1_valid_q)) < (CntW + 1)'(Depth);
    mid_pop_o = ~mid_empty_i & credit;
    frac      = mid_data_i.raw[FRAC_MSB:FRAC_LSB];
    prod_d    = mid_data_i.span * $signed({1'b0, frac});
    rsp_d.raw_value     = raw_q;
    rsp_d.unit_fraction = raw_q[FRAC_MSB:FRAC_LSB];
    rsp_d.scaled_value  = low_q + prod_q[55:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= mid_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      raw_q  <= mid_data_i.raw;
      low_q  <= mid_data_i.low;
      prod_q <= prod_d;
    end
  end

  xrs_fifo #(
    .Width($bits(xrs_rsp_t)),
    .Depth(Depth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s1_valid_q),
    .data_i (rsp_d),
    .full_o (out_full),
    .pop_i  (out_pop_i),
    .data_o (rsp_q),
    .empty_o(out_empty_o),
    .count_o(out_count)
  );

  assign rsp_o = rsp_q;

endmodule

/* rtl/core/xoroshiro128_plus_generator.sv */
// Top level of the xoroshiro128+ generator with a signed Q16.16 range scaler.
// Accepts one request per cycle while full is low; each result passes through the mid queue,
// the scaling register and the output queue before it is shown. After reset and after each seed
// write the seed expander runs, with full held high, until the state is that of the seed; seed resets to one.
// Depends on xrs_pkg, xrs_seed_expander, xrs_front, xrs_fifo and xrs_back.
module xoroshiro128_plus_generator import xrs_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  xrs_req_t              req_i,
  output logic                  empty,
  input  logic                  pop,
  output xrs_rsp_t              rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam int unsigned MidCntW = $clog2(QueueDepth + 1);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_we;
  logic [63:0]          seed;
  xrs_seed_t            exp_st;
  logic                 mid_push, mid_full, mid_pop, mid_empty;
  xrs_mid_t             mid_wdata, mid_rdata;
  logic [MidCntW-1:0]   mid_count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
  assign cfg_we  = psel & penable & pwrite & pready & (reg_idx == REG_SEED);
  assign prdata  = (reg_idx == REG_SEED) ? seed : '0;

  xrs_seed_expander u_expander (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(pwdata),
    .seed_o    (seed),
    .exp_o     (exp_st)
  );

  xrs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .exp_i     (exp_st),
    .push_i    (push),
    .req_i     (req_i),
    .full_o    (full),
    .mid_push_o(mid_push),
    .mid_data_o(mid_wdata),
    .mid_full_i(mid_full)
  );

  xrs_fifo #(
    .Width($bits(xrs_mid_t)),
    .Depth(QueueDepth)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .data_i (mid_wdata),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .data_o (mid_rdata),
    .empty_o(mid_empty),
    .count_o(mid_count)
  );

  xrs_back #(
    .Depth(QueueDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_empty_i(mid_empty | (mid_count == '0)),
    .mid_data_i (mid_rdata),
    .mid_pop_o  (mid_pop),
    .out_pop_i  (pop),
    .out_empty_o(empty),
    .rsp_o      (rsp_o)
  );

endmodule

/* dv/xoroshiro128_plus_generator_tb.sv */
// Self-checking testbench for the xoroshiro128+ generator: a directed table, then random draws
// in three back-pressure phases, all checked against an in-bench predictor of the generator.
// Depends on xrs_pkg and the xoroshiro128_plus_generator top level.
module xoroshiro128_plus_generator_tb;
  import xrs_pkg::*;

  localparam logic [63:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL2  = 64'h94D0_49BB_1331_11EB;

  localparam logic [APB_ADDR_W-1:0] SEED_ADDR  = 4'h0;
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 4'h8;

  localparam int QUIET_LIMIT = 2000;
  localparam int DIRECTED_ROWS = 21;
  localparam int DRAWS_PER_PHASE = 184;

  typedef enum logic [1:0] {
    ROW_DRAW,
    ROW_SEED,
    ROW_SPARE
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [63:0] data;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        pinned;
    logic [31:0] pin_value;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  xrs_req_t              req = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  xrs_rsp_t              rsp;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [63:0]           pwdata = '0;
  logic [63:0]           prdata;
  logic                  pready;

  logic [63:0] seed_reg;
  logic [63:0] state_a;
  logic [63:0] state_b;
  xrs_rsp_t    pending_draws [$];
  xrs_rsp_t    want;
  int          errors = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 37;
  int          recv_idle_pct = 51;
  stim_row_t   directed [DIRECTED_ROWS];
  logic [31:0] corner_vals [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

  xoroshiro128_plus_generator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .req_i   (req),
    .empty   (empty),
    .pop     (pop),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rol64(logic [63:0] v, int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  // Two SplitMix64 steps fill both state words; a zero seed behaves as one.
  function automatic void load_seed(logic [63:0] s);
    logic [63:0] acc;
    logic [63:0] z;
    acc = (s == 64'd0) ? 64'd1 : s;
    for (int k = 0; k < 2; k++) begin
      acc = acc + MIX_GAMMA;
      z = acc;
      z = (z ^ (z >> 30)) * MIX_MUL1;
      z = (z ^ (z >> 27)) * MIX_MUL2;
      z = z ^ (z >> 31);
      if (k == 0) begin
        state_a = z;
      end else begin
        state_b = z;
      end
    end
  endfunction

  function automatic xrs_rsp_t draw_sample(xrs_req_t r);
    xrs_rsp_t           d;
    logic [63:0]        s0;
    logic [63:0]        s1;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic signed [63:0] span;
    logic signed [63:0] prod;
    logic signed [63:0] total;
    s0 = state_a;
    s1 = state_b;
    d.raw_value = s0 + s1;
    d.unit_fraction = d.raw_value[63:40];
    lo = {{32{r.range_low[31]}}, r.range_low};
    hi = {{32{r.range_high[31]}}, r.range_high};
    span = hi - lo;
    prod = span * $signed({40'd0, d.unit_fraction});
    total = lo + (prod >>> 24);
    d.scaled_value = total[31:0];
    s1 = s1 ^ s0;
    state_a = rol64(s0, 55) ^ s1 ^ (s1 << 14);
    state_b = rol64(s1, 36);
    return d;
  endfunction

  task automatic send_draw(xrs_req_t r, logic pinned, logic [31:0] pin_value);
    xrs_rsp_t d;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    req <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    d = draw_sample(r);
    if (pinned) begin
      d.scaled_value = pin_value;
    end
    pending_draws.push_back(d);
  endtask

  task automatic drain_draws();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_draws.size() != 0) @(posedge clk_i);
  endtask

  // Waits for all outstanding draws to drain, writes one register, then reads the seed back.
  task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [63:0] data);
    drain_draws();
    repeat (4) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == SEED_ADDR) begin
      seed_reg = data;
      load_seed(data);
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= SEED_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== seed_reg) begin
      $display("%0t seed readback expected %h actual %h", $time, seed_reg, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (pending_draws.size() == 0) begin
        $display("%0t unexpected beat raw_value %h", $time, rsp.raw_value);
        errors++;
      end else begin
        want = pending_draws.pop_front();
        if (rsp.raw_value !== want.raw_value) begin
          $display("%0t raw_value expected %h actual %h", $time, want.raw_value, rsp.raw_value);
          errors++;
        end
        if (rsp.unit_fraction !== want.unit_fraction) begin
          $display("%0t unit_fraction expected %h actual %h", $time, want.unit_fraction,
                   rsp.unit_fraction);
          errors++;
        end
        if (rsp.scaled_value !== want.scaled_value) begin
          $display("%0t scaled_value expected %h actual %h", $time, want.scaled_value,
                   rsp.scaled_value);
          errors++;
        end
      end
    end
    if ((pop && !empty) || (push && !full) || (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL xoroshiro128_plus_generator");
      $finish;
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    xrs_req_t    rq;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] t;
    logic [63:0] sd;
    seed_reg = 64'd1;
    load_seed(64'd1);
    directed[0]  = '{ROW_DRAW,  64'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000};
    directed[1]  = '{ROW_DRAW,  64'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF};
    directed[2]  = '{ROW_DRAW,  64'd0, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000};
    directed[3]  = '{ROW_DRAW,  64'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0};
    directed[4]  = '{ROW_DRAW,  64'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0};
    directed[5]  = '{ROW_DRAW,  64'd0, 32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0};
    directed[6]  = '{ROW_DRAW,  64'd0, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0};
    directed[7]  = '{ROW_DRAW,  64'd0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0};
    directed[8]  = '{ROW_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0};
    directed[9]  = '{ROW_DRAW,  64'd0, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0};
    directed[10] = '{ROW_SEED,  64'd0, 32'h0, 32'h0, 1'b0, 32'h0};
    directed[11] = '{ROW_DRAW,  64'd0, 32'h1234_5678, 32'h1234_5678, 1'b1, 32'h1234_5678};
    directed[12] = '{ROW_DRAW,  64'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0};
    directed[13] = '{ROW_SEED,  64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0};
    directed[14] = '{ROW_DRAW,  64'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0};
    directed[15] = '{ROW_DRAW,  64'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0};
    directed[16] = '{ROW_SEED,  64'h8000_0000_0000_0000, 32'h0, 32'h0, 1'b0, 32'h0};
    directed[17] = '{ROW_DRAW,  64'd0, 32'hFFFF_0000, 32'h0001_0000, 1'b0, 32'h0};
    directed[18] = '{ROW_SEED,  64'd1, 32'h0, 32'h0, 1'b0, 32'h0};
    directed[19] = '{ROW_DRAW,  64'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000};
    directed[20] = '{ROW_DRAW,  64'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      case (directed[i].kind)
        ROW_DRAW: begin
          rq.range_low = directed[i].lo;
          rq.range_high = directed[i].hi;
          send_draw(rq, directed[i].pinned, directed[i].pin_value);
        end
        ROW_SEED: begin
          reg_write(SEED_ADDR, directed[i].data);
        end
        default: begin
          reg_write(SPARE_ADDR, directed[i].data);
        end
      endcase
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 37 : 0;
      if (phase == 1) begin
        reg_write(SEED_ADDR, {$urandom, $urandom});
      end else if (phase == 2) begin
        reg_write(SEED_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
      end
      for (int n = 0; n < DRAWS_PER_PHASE; n++) begin
        if (n % 61 == 60) begin
          case ($urandom_range(3))
            0: sd = 64'd0;
            1: sd = 64'hFFFF_FFFF_FFFF_FFFF;
            default: sd = {$urandom, $urandom};
          endcase
          reg_write(SEED_ADDR, sd);
        end else if ($urandom_range(99) == 0) begin
          drain_draws();
        end
        a = $urandom;
        b = $urandom;
        case ($urandom_range(5))
          2: b = a + $urandom_range(262144);
          3: b = a;
          4: begin
            a = corner_vals[$urandom_range(3)];
            b = corner_vals[$urandom_range(3)];
          end
          5: begin
            if ($signed(b) > $signed(a)) begin
              t = a;
              a = b;
              b = t;
            end
          end
          default: ;
        endcase
        rq.range_low = a;
        rq.range_high = b;
        send_draw(rq, 1'b0, 32'h0);
      end
    end

    drain_draws();
    repeat (8) @(posedge clk_i);
    if (pending_draws.size() != 0) begin
      errors++;
    end
    if (errors == 0) begin
      $display("PASS xoroshiro128_plus_generator");
    end else begin
      $display("FAIL xoroshiro128_plus_generator");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/xrs_pkg.sv
rtl/core/xrs_fifo.sv
rtl/core/xrs_seed_expander.sv
rtl/core/xrs_front.sv
rtl/core/xrs_back.sv
rtl/core/xoroshiro128_plus_generator.sv
dv/xoroshiro128_plus_generator_tb.sv
